// ===== sv/assert_macros.svh =====
// Assertion macros shared by the filter's RTL files.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define BQF_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define BQF_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== sv/bqf_pkg.sv =====
// Shared constants, payload structs and state types of the biquad cascade.
// Used by bqf_section, cascaded_biquad_iir_filter and the testbench.
package bqf_pkg;

   localparam int SECTIONS       = 4;
   localparam int SAMPLE_WIDTH   = 24;
   localparam int COEF_FRAC_BITS = 28;
   localparam int COEF_WIDTH     = 32;
   localparam int TAPS           = 5;
   localparam int NUM_COEFS      = SECTIONS * TAPS;
   localparam int COEF_IDX_WIDTH = 5;
   localparam int TAP_WIDTH      = 3;
   localparam int PROD_WIDTH     = COEF_WIDTH + SAMPLE_WIDTH;
   localparam int ACC_WIDTH      = PROD_WIDTH + 3;
   localparam int ROUND_WIDTH    = ACC_WIDTH - COEF_FRAC_BITS;

   typedef logic [TAP_WIDTH-1:0] tap_type;

   // Coefficient positions inside one section, also the sequencer steps.
   localparam tap_type TAP_B0     = 3'd0;
   localparam tap_type TAP_B1     = 3'd1;
   localparam tap_type TAP_B2     = 3'd2;
   localparam tap_type TAP_A1     = 3'd3;
   localparam tap_type TAP_A2     = 3'd4;
   localparam tap_type STEP_DRAIN = 3'd5;
   localparam tap_type STEP_FINAL = 3'd6;

   localparam logic KIND_COEF   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS =
      ACC_WIDTH'(64'sd1 <<< (COEF_FRAC_BITS - 1));
   localparam logic signed [ROUND_WIDTH-1:0] SAMPLE_MAX =
      ROUND_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [ROUND_WIDTH-1:0] SAMPLE_MIN =
      ROUND_WIDTH'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;

   typedef struct packed {
      logic                      kind;
      sample_type                sample_in;
      logic [COEF_IDX_WIDTH-1:0] coef_index;
      coef_type                  coef_value;
   } req_type;

   typedef struct packed {
      sample_type sample_out;
      logic       saturated;
   } rsp_type;

   // Sample handed from one section to the next.
   typedef struct packed {
      logic       valid;
      sample_type sample;
      logic       sat;
   } link_type;

   // Coefficient write steered to one section.
   typedef struct packed {
      logic     we;
      tap_type  pos;
      coef_type value;
   } coef_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

endpackage

// ===== sv/bqf_section.sv =====
// One second-order section: coefficients, history and a shared multiply-accumulate.
// Depends on bqf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bqf_section (
   input  logic                 clock,
   input  logic                 reset,
   input  bqf_pkg::coef_wr_type coef_wr,
   input  bqf_pkg::link_type    link_in,
   output bqf_pkg::link_type    link_out,
   output logic                 busy
);

   localparam int PW = bqf_pkg::PROD_WIDTH;
   localparam int AW = bqf_pkg::ACC_WIDTH;
   localparam int YW = bqf_pkg::ROUND_WIDTH;
   localparam int SW = bqf_pkg::SAMPLE_WIDTH;
   localparam int F  = bqf_pkg::COEF_FRAC_BITS;

   bqf_pkg::coef_type   coef_ff [bqf_pkg::TAPS];
   bqf_pkg::sample_type x1_ff, x1_in, x2_ff, x2_in;
   bqf_pkg::sample_type y1_ff, y1_in, y2_ff, y2_in;
   bqf_pkg::sample_type cur_ff, cur_in;
   logic                sat_carry_ff, sat_carry_in;
   logic                busy_ff, busy_in;
   bqf_pkg::tap_type    cnt_ff, cnt_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic                prod_valid_ff, prod_valid_in;
   logic                sub_ff, sub_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   bqf_pkg::sample_type out_sample_ff, out_sample_in;
   logic                out_sat_ff, out_sat_in;
   logic                done_ff, done_in;

   bqf_pkg::coef_type   coef_sel;
   bqf_pkg::sample_type op_sel;
   logic signed [YW-1:0] y_wide;
   bqf_pkg::sample_type y_sat;
   logic                clip;

   // Coefficient and operand for the current multiply step.
   always_comb begin
      coef_sel = '0;
      for (int i = 0; i < bqf_pkg::TAPS; i++) begin
         if (cnt_ff == bqf_pkg::tap_type'(i)) begin
            coef_sel = coef_ff[i];
         end
      end
      case (cnt_ff)
         bqf_pkg::TAP_B0: op_sel = cur_ff;
         bqf_pkg::TAP_B1: op_sel = x1_ff;
         bqf_pkg::TAP_B2: op_sel = x2_ff;
         bqf_pkg::TAP_A1: op_sel = y1_ff;
         bqf_pkg::TAP_A2: op_sel = y2_ff;
         default:         op_sel = '0;
      endcase
   end

   // The accumulator starts at the rounding bias, so the final shift rounds to nearest.
   assign y_wide = acc_ff[AW-1:F];
   assign clip   = (y_wide > bqf_pkg::SAMPLE_MAX) || (y_wide < bqf_pkg::SAMPLE_MIN);
   always_comb begin
      if (y_wide > bqf_pkg::SAMPLE_MAX) begin
         y_sat = SW'(bqf_pkg::SAMPLE_MAX);
      end else if (y_wide < bqf_pkg::SAMPLE_MIN) begin
         y_sat = SW'(bqf_pkg::SAMPLE_MIN);
      end else begin
         y_sat = SW'(y_wide);
      end
   end

   always_comb begin
      x1_in         = x1_ff;
      x2_in         = x2_ff;
      y1_in         = y1_ff;
      y2_in         = y2_ff;
      cur_in        = cur_ff;
      sat_carry_in  = sat_carry_ff;
      busy_in       = busy_ff;
      cnt_in        = cnt_ff;
      prod_in       = coef_sel * op_sel;
      prod_valid_in = 1'b0;
      sub_in        = (cnt_ff == bqf_pkg::TAP_A1) || (cnt_ff == bqf_pkg::TAP_A2);
      acc_in        = acc_ff;
      out_sample_in = out_sample_ff;
      out_sat_in    = out_sat_ff;
      done_in       = 1'b0;
      if (link_in.valid) begin
         busy_in      = 1'b1;
         cnt_in       = bqf_pkg::TAP_B0;
         cur_in       = link_in.sample;
         sat_carry_in = link_in.sat;
         acc_in       = bqf_pkg::ROUND_BIAS;
      end else if (busy_ff) begin
         cnt_in        = cnt_ff + bqf_pkg::tap_type'(1);
         prod_valid_in = (cnt_ff < bqf_pkg::STEP_DRAIN);
         if (prod_valid_ff) begin
            if (sub_ff) begin
               acc_in = acc_ff - AW'(prod_ff);
            end else begin
               acc_in = acc_ff + AW'(prod_ff);
            end
         end
         if (cnt_ff == bqf_pkg::STEP_FINAL) begin
            busy_in       = 1'b0;
            done_in       = 1'b1;
            x2_in         = x1_ff;
            x1_in         = cur_ff;
            y2_in         = y1_ff;
            y1_in         = y_sat;
            out_sample_in = y_sat;
            out_sat_in    = sat_carry_ff | clip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bqf_pkg::TAPS; i++) begin
            coef_ff[i] <= '0;
         end
         x1_ff         <= '0;
         x2_ff         <= '0;
         y1_ff         <= '0;
         y2_ff         <= '0;
         busy_ff       <= 1'b0;
         cnt_ff        <= bqf_pkg::TAP_B0;
         prod_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         for (int i = 0; i < bqf_pkg::TAPS; i++) begin
            if (coef_wr.we && coef_wr.pos == bqf_pkg::tap_type'(i)) begin
               coef_ff[i] <= coef_wr.value;
            end
         end
         x1_ff         <= x1_in;
         x2_ff         <= x2_in;
         y1_ff         <= y1_in;
         y2_ff         <= y2_in;
         busy_ff       <= busy_in;
         cnt_ff        <= cnt_in;
         prod_valid_ff <= prod_valid_in;
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      sat_carry_ff  <= sat_carry_in;
      prod_ff       <= prod_in;
      sub_ff        <= sub_in;
      acc_ff        <= acc_in;
      out_sample_ff <= out_sample_in;
      out_sat_ff    <= out_sat_in;
   end

   assign link_out.valid  = done_ff;
   assign link_out.sample = out_sample_ff;
   assign link_out.sat    = out_sat_ff;
   assign busy            = busy_ff;

   `BQF_ASSERT_NEVER(a_no_start_while_busy, clock, reset, link_in.valid && busy_ff, "section started while busy")
   `BQF_ASSERT_NEVER(a_step_in_range, clock, reset, busy_ff && (cnt_ff > bqf_pkg::STEP_FINAL), "section step counter out of range")

endmodule

// ===== sv/cascaded_biquad_iir_filter.sv =====
// Channel  | Ports                             | Transfer
// req      | req_valid, req_ready, req_data    | req_valid && req_ready
// rsp      | rsp_valid, rsp_ready, rsp_data    | rsp_valid && rsp_ready
// A coefficient write leaves the block idle; req_ready stays high.
// In each section a sample goes through five products on the section's one
// multiplier, a final add, then round and saturate, and is then handed on;
// rsp_valid rises with the result of the last section, req_ready in the same cycle.
// Synchronous reset clears coefficients, history and all handshake state.
// A result waiting on rsp_ready holds the next sample's result in the last section.
// Top level of the biquad cascade: request decode, section chain, result register.
// Depends on bqf_pkg, bqf_section and assert_macros.svh.
`include "assert_macros.svh"

module cascaded_biquad_iir_filter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bqf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bqf_pkg::rsp_type rsp_data
);

   localparam int NS = bqf_pkg::SECTIONS;

   bqf_pkg::state_type   state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bqf_pkg::rsp_type     rsp_ff, rsp_in;
   logic                 accept;
   logic                 start;
   logic                 rsp_free;
   logic                 load;
   bqf_pkg::coef_wr_type coef_wr [NS];
   bqf_pkg::link_type    link [NS+1];
   logic [NS-1:0]        sect_busy;

   assign accept   = req_valid && req_ready;
   assign start    = accept && (req_data.kind == bqf_pkg::KIND_SAMPLE);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Steer a coefficient write to the section that owns its index.
   always_comb begin
      for (int s = 0; s < NS; s++) begin
         coef_wr[s].we    = accept && (req_data.kind == bqf_pkg::KIND_COEF) &&
                            (int'(req_data.coef_index) >= s * bqf_pkg::TAPS) &&
                            (int'(req_data.coef_index) < (s + 1) * bqf_pkg::TAPS);
         coef_wr[s].pos   = bqf_pkg::tap_type'(int'(req_data.coef_index) -
                                               s * bqf_pkg::TAPS);
         coef_wr[s].value = req_data.coef_value;
      end
   end

   assign link[0].valid  = start;
   assign link[0].sample = req_data.sample_in;
   assign link[0].sat    = 1'b0;

   for (genvar s = 0; s < NS; s++) begin : g_section
      bqf_section u_section (
         .clock    (clock),
         .reset    (reset),
         .coef_wr  (coef_wr[s]),
         .link_in  (link[s]),
         .link_out (link[s+1]),
         .busy     (sect_busy[s])
      );
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      load      = 1'b0;
      case (state_ff)
         bqf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (start) begin
               state_in = bqf_pkg::ST_RUN;
            end
         end
         bqf_pkg::ST_RUN: begin
            if (link[NS].valid) begin
               if (rsp_free) begin
                  load     = 1'b1;
                  state_in = bqf_pkg::ST_IDLE;
               end else begin
                  state_in = bqf_pkg::ST_HOLD;
               end
            end
         end
         bqf_pkg::ST_HOLD: begin
            if (rsp_free) begin
               load     = 1'b1;
               state_in = bqf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bqf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in      = 1'b1;
         rsp_in.sample_out = link[NS].sample;
         rsp_in.saturated  = link[NS].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bqf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BQF_ASSERT(a_one_section_busy, clock, reset, $onehot0(sect_busy), "more than one section busy")
   `BQF_ASSERT(a_done_only_in_run, clock, reset, link[NS].valid |-> (state_ff == bqf_pkg::ST_RUN), "chain finished outside a run")
   `BQF_ASSERT(a_sample_blocks, clock, reset, start |=> !req_ready, "request taken while a sample is in flight")
   `BQF_ASSERT(a_rsp_from_run, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) != bqf_pkg::ST_IDLE), "result appeared without a sample")

endmodule

// ===== tb/tb_cascaded_biquad_iir_filter.sv =====
// Self-checking testbench for the cascaded biquad IIR filter: a queue-fed driver,
// a bit-exact filter predictor and a result monitor with random back-pressure.
// Depends on bqf_pkg and the cascaded_biquad_iir_filter RTL.
module tb_cascaded_biquad_iir_filter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1950;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8 * bqf_pkg::SECTIONS + 12;
   localparam int IDX_WIDTH    = bqf_pkg::COEF_IDX_WIDTH;
   localparam int TOP_INDEX    = (1 << IDX_WIDTH) - 1;

   localparam bqf_pkg::coef_type COEF_ONE  =
      bqf_pkg::coef_type'(1 << bqf_pkg::COEF_FRAC_BITS);
   localparam bqf_pkg::coef_type COEF_HALF =
      bqf_pkg::coef_type'(1 << (bqf_pkg::COEF_FRAC_BITS - 1));
   localparam bqf_pkg::coef_type COEF_MAX  = bqf_pkg::coef_type'(32'h7FFF_FFFF);
   localparam bqf_pkg::coef_type COEF_MIN  = bqf_pkg::coef_type'(32'h8000_0000);
   localparam bqf_pkg::sample_type SMP_MAX =
      bqf_pkg::sample_type'((1 << (bqf_pkg::SAMPLE_WIDTH - 1)) - 1);
   localparam bqf_pkg::sample_type SMP_MIN =
      bqf_pkg::sample_type'(1 << (bqf_pkg::SAMPLE_WIDTH - 1));

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   bqf_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   bqf_pkg::rsp_type rsp_data;

   // Predictor state: coefficient table and per-section x1/x2, y1/y2.
   bqf_pkg::coef_type   coef_mem [bqf_pkg::NUM_COEFS];
   bqf_pkg::sample_type x_hist [bqf_pkg::SECTIONS][2];
   bqf_pkg::sample_type y_hist [bqf_pkg::SECTIONS][2];

   bqf_pkg::req_type req_backlog [$];
   bqf_pkg::rsp_type filtered_q [$];

   int               errors = 0;
   int               idle_cycles = 0;
   int               req_count = 0;
   int               rsp_count = 0;
   int               send_wait = 0;
   int               recv_wait = 0;
   int               next_gap;
   bqf_pkg::rsp_type predicted;
   bqf_pkg::rsp_type oldest;

   cascaded_biquad_iir_filter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Applies one request to the predictor; returns 1 when it yields a sample.
   function automatic bit filter_step(input bqf_pkg::req_type r,
                                      output bqf_pkg::rsp_type res);
      longint acc;
      longint y;
      longint cur;
      bit     clipped;
      int     base;
      res = '0;
      clipped = 1'b0;
      if (r.kind == bqf_pkg::KIND_COEF) begin
         if (r.coef_index < bqf_pkg::NUM_COEFS) coef_mem[r.coef_index] = r.coef_value;
         return 1'b0;
      end
      cur = r.sample_in;
      for (int s = 0; s < bqf_pkg::SECTIONS; s++) begin
         base = s * bqf_pkg::TAPS;
         acc = longint'(coef_mem[base + bqf_pkg::TAP_B0]) * cur
             + longint'(coef_mem[base + bqf_pkg::TAP_B1]) * longint'(x_hist[s][0])
             + longint'(coef_mem[base + bqf_pkg::TAP_B2]) * longint'(x_hist[s][1])
             - longint'(coef_mem[base + bqf_pkg::TAP_A1]) * longint'(y_hist[s][0])
             - longint'(coef_mem[base + bqf_pkg::TAP_A2]) * longint'(y_hist[s][1]);
         // Round half up, then clip to the sample range.
         y = (acc + (longint'(1) <<< (bqf_pkg::COEF_FRAC_BITS - 1)))
             >>> bqf_pkg::COEF_FRAC_BITS;
         if (y > bqf_pkg::SAMPLE_MAX) begin
            y = bqf_pkg::SAMPLE_MAX;
            clipped = 1'b1;
         end else if (y < bqf_pkg::SAMPLE_MIN) begin
            y = bqf_pkg::SAMPLE_MIN;
            clipped = 1'b1;
         end
         x_hist[s][1] = x_hist[s][0];
         x_hist[s][0] = bqf_pkg::sample_type'(cur);
         y_hist[s][1] = y_hist[s][0];
         y_hist[s][0] = bqf_pkg::sample_type'(y);
         cur = y;
      end
      res.sample_out = bqf_pkg::sample_type'(cur);
      res.saturated  = clipped;
      return 1'b1;
   endfunction

   // Every 128 transfers, the last 32 go without idling.
   function automatic int draw_gap(int count);
      return ((count % 128) >= 96) ? 0 : $urandom_range(0, 8);
   endfunction

   task automatic push_coef(int idx, bqf_pkg::coef_type value);
      bqf_pkg::req_type r;
      r.kind       = bqf_pkg::KIND_COEF;
      r.sample_in  = bqf_pkg::sample_type'($urandom);
      r.coef_index = IDX_WIDTH'(idx);
      r.coef_value = value;
      req_backlog.push_back(r);
   endtask

   task automatic push_sample(bqf_pkg::sample_type value);
      bqf_pkg::req_type r;
      r.kind       = bqf_pkg::KIND_SAMPLE;
      r.sample_in  = value;
      r.coef_index = IDX_WIDTH'($urandom);
      r.coef_value = bqf_pkg::coef_type'($urandom);
      req_backlog.push_back(r);
   endtask

   function automatic bqf_pkg::sample_type random_sample();
      case ($urandom_range(0, 5)) inside
         0:       return SMP_MAX;
         1:       return SMP_MIN;
         [2:3]:   return bqf_pkg::sample_type'($urandom);
         default: return bqf_pkg::sample_type'(int'($urandom_range(0, 8191)) - 4096);
      endcase
   endfunction

   // Within +/-0.5, which keeps a section stable.
   function automatic bqf_pkg::coef_type tame_coef();
      return bqf_pkg::coef_type'(int'($urandom_range(0, 1 << 28)) - (1 << 27));
   endfunction

   task automatic load_tame_section(int sec);
      for (int t = 0; t < bqf_pkg::TAPS; t++) push_coef(sec * bqf_pkg::TAPS + t, tame_coef());
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Request driver. The gap counts cycles in which the block is ready.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else if (req_valid && req_ready) begin
         if (filter_step(req_data, predicted)) filtered_q.push_back(predicted);
         req_count = req_count + 1;
         next_gap = draw_gap(req_count);
         if (next_gap == 0 && req_backlog.size() > 0) begin
            req_data <= req_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
            send_wait <= next_gap;
         end
      end else if (!req_valid) begin
         if (send_wait > 0) begin
            if (req_ready) send_wait <= send_wait - 1;
         end else if (req_backlog.size() > 0) begin
            req_data  <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // Result monitor. After a transfer, ready stays low for a drawn number of
   // cycles in which a result is offered.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (filtered_q.size() == 0) begin
            $display("%0t: unexpected result sample_out %0d saturated %0b",
                     $time, rsp_data.sample_out, rsp_data.saturated);
            errors = errors + 1;
         end else begin
            oldest = filtered_q.pop_front();
            if (rsp_data.sample_out !== oldest.sample_out) begin
               $display("%0t: sample_out expected %0d, actual %0d",
                        $time, oldest.sample_out, rsp_data.sample_out);
               errors = errors + 1;
            end
            if (rsp_data.saturated !== oldest.saturated) begin
               $display("%0t: saturated expected %0b, actual %0b",
                        $time, oldest.saturated, rsp_data.saturated);
               errors = errors + 1;
            end
         end
         rsp_count = rsp_count + 1;
         next_gap = draw_gap(rsp_count);
         if (next_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_wait <= next_gap;
         end
      end else if (!rsp_ready && (rsp_valid || recv_wait == 0)) begin
         if (recv_wait <= 1) begin
            rsp_ready <= 1'b1;
            recv_wait <= 0;
         end else begin
            recv_wait <= recv_wait - 1;
         end
      end
   end

   initial begin
      int n;
      int stim_count;
      int sec;
      foreach (coef_mem[i]) coef_mem[i] = '0;
      foreach (x_hist[s, k]) begin
         x_hist[s][k] = '0;
         y_hist[s][k] = '0;
      end

      // All coefficients are zero after reset, so the output is zero.
      push_sample(SMP_MAX);
      push_sample(SMP_MIN);
      // Unity gain through every section.
      for (int s = 0; s < bqf_pkg::SECTIONS; s++)
         push_coef(s * bqf_pkg::TAPS + bqf_pkg::TAP_B0, COEF_ONE);
      push_sample(SMP_MAX);
      push_sample(SMP_MIN);
      push_sample('0);
      push_sample(bqf_pkg::sample_type'(-1));
      // A half gain puts +/-1 exactly on the rounding tie.
      push_coef(bqf_pkg::TAP_B0, COEF_HALF);
      push_sample(bqf_pkg::sample_type'(1));
      push_sample(bqf_pkg::sample_type'(-1));
      // Coefficient extremes of both signs drive the first section into its upper bound.
      push_coef(bqf_pkg::TAP_B0, COEF_MAX);
      push_sample(SMP_MAX);
      push_coef(bqf_pkg::TAP_B0, COEF_MIN);
      push_sample(SMP_MIN);
      // Writes past the table must leave it alone.
      push_coef(bqf_pkg::NUM_COEFS, COEF_MAX);
      push_coef(TOP_INDEX, COEF_MIN);
      push_sample(bqf_pkg::sample_type'(1000));
      push_coef((bqf_pkg::SECTIONS - 1) * bqf_pkg::TAPS + bqf_pkg::TAP_A1, COEF_MAX);
      push_sample(SMP_MAX);

      stim_count = 0;
      while (stim_count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 31)) inside
            [18:24]: begin
               load_tame_section($urandom_range(0, bqf_pkg::SECTIONS - 1));
               stim_count += bqf_pkg::TAPS;
            end
            [25:27]: begin
               for (sec = 0; sec < bqf_pkg::SECTIONS; sec++) load_tame_section(sec);
               stim_count += bqf_pkg::NUM_COEFS;
            end
            28: begin
               push_coef($urandom_range(0, bqf_pkg::NUM_COEFS - 1),
                         bqf_pkg::coef_type'($urandom));
               stim_count += 1;
            end
            [29:31]: begin
               push_coef($urandom_range(bqf_pkg::NUM_COEFS, TOP_INDEX),
                         bqf_pkg::coef_type'($urandom));
               stim_count += 1;
            end
            default: begin
               n = $urandom_range(4, 30);
               repeat (n) push_sample(random_sample());
               stim_count += n;
            end
         endcase
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (!(req_backlog.size() == 0 && !req_valid && filtered_q.size() == 0)
             && idle_cycles < IDLE_LIMIT)
         @(posedge clock);

      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, filtered_q.size());
         $display("tb: failure");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         if (filtered_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, filtered_q.size());
            errors = errors + 1;
         end
         if (errors == 0) begin
            $display("tb: success");
         end else begin
            $display("tb: failure");
         end
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/bqf_pkg.sv
sv/bqf_section.sv
sv/cascaded_biquad_iir_filter.sv
tb/tb_cascaded_biquad_iir_filter.sv
